FILE: design/tcce_pkg.sv
// Shared types and constants for the text console character engine.
`default_nettype none

package tcce_pkg;

  localparam logic [1:0] CMD_PUT   = 2'd0;
  localparam logic [1:0] CMD_CLEAR = 2'd1;
  localparam logic [1:0] CMD_READ  = 2'd2;

  localparam logic [7:0] CH_BS         = 8'h08;
  localparam logic [7:0] CH_TAB        = 8'h09;
  localparam logic [7:0] CH_LF         = 8'h0A;
  localparam logic [7:0] CH_CR         = 8'h0D;
  localparam logic [7:0] CH_SPACE      = 8'h20;
  localparam logic [7:0] CH_LAST_PRINT = 8'h7F;

  localparam logic [7:0]  RESET_ATTR  = 8'h07;
  localparam logic [15:0] RESET_BLANK = {RESET_ATTR, CH_SPACE};

  localparam int QUEUE_DEPTH = 2;

  typedef enum logic [2:0] {
    OP_NOP,
    OP_GLYPH,
    OP_BS,
    OP_TAB,
    OP_CR,
    OP_LF,
    OP_CLEAR,
    OP_READ
  } op_t;

  typedef struct packed {
    op_t         op;
    logic [7:0]  ch;
    logic [10:0] addr;
  } q_entry_t;

  typedef enum logic [1:0] {
    ST_INIT,
    ST_IDLE,
    ST_FILL,
    ST_DONE
  } back_state_t;

endpackage

`default_nettype wire

FILE: design/tcce_front.sv
// Front end: accepts input beats and classifies them into console operations.
`default_nettype none

module tcce_front
  import tcce_pkg::*;
(
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  cmd,
  input  wire logic [7:0]  char_code,
  input  wire logic [10:0] read_addr,
  input  wire logic        q_full,
  input  wire logic        init_busy,
  output logic             push,
  output q_entry_t         push_entry
);

  op_t op;

  always_comb begin
    op = OP_NOP;
    case (cmd)
      CMD_PUT: begin
        if (char_code == CH_BS) begin
          op = OP_BS;
        end else if (char_code == CH_TAB) begin
          op = OP_TAB;
        end else if (char_code == CH_CR) begin
          op = OP_CR;
        end else if (char_code == CH_LF) begin
          op = OP_LF;
        end else if (char_code >= CH_SPACE && char_code <= CH_LAST_PRINT) begin
          op = OP_GLYPH;
        end
      end
      CMD_CLEAR: op = OP_CLEAR;
      CMD_READ:  op = OP_READ;
      default:   op = OP_NOP;
    endcase
  end

  assign in_stall        = q_full || init_busy;
  assign push            = in_valid && !in_stall;
  assign push_entry.op   = op;
  assign push_entry.ch   = char_code;
  assign push_entry.addr = read_addr;

endmodule

`default_nettype wire

FILE: design/tcce_queue.sv
// Short queue of classified operations between the front and back ends.
`default_nettype none

module tcce_queue
  import tcce_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     push,
  input  q_entry_t      push_entry,
  input  wire logic     pop,
  output q_entry_t      head,
  output logic          full,
  output logic          empty
);

  localparam int QAW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

  q_entry_t         slots [QUEUE_DEPTH];
  logic [QAW-1:0]   wr_ptr;
  logic [QAW-1:0]   rd_ptr;
  logic [QAW:0]     count;

  assign full  = (count == (QAW+1)'(QUEUE_DEPTH));
  assign empty = (count == '0);
  assign head  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QAW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QAW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

FILE: design/tcce_back.sv
// Back end: screen memory with row-rotating scroll, cursor logic and result register.
`default_nettype none

module tcce_back
  import tcce_pkg::*;
#(
  parameter int COLUMNS  = 80,
  parameter int ROWS     = 25,
  parameter int TAB_STOP = 8
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  q_entry_t         head,
  input  wire logic        q_empty,
  output logic             q_pop,
  output logic             init_busy,
  input  wire logic        attr_we,
  input  wire logic [7:0]  attr_data,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [15:0]      read_cell,
  output logic [10:0]      cursor_pos,
  output logic [6:0]       cursor_col,
  output logic [4:0]       cursor_row
);

  localparam int CELLS = COLUMNS * ROWS;
  localparam int AW    = $clog2(CELLS);
  localparam int CW    = $clog2(COLUMNS);
  localparam int LW    = $clog2(ROWS);
  localparam int TW    = $clog2(COLUMNS + TAB_STOP);
  localparam int SW    = ((AW > 11) ? AW : 11) + 1;
  localparam int MAXM  = (COLUMNS - 1) / TAB_STOP + 1;

  back_state_t state;
  back_state_t state_next;

  logic [15:0]   mem [CELLS];
  logic [15:0]   rd_data;

  logic [7:0]    attr;
  logic [CW-1:0] col;
  logic [LW-1:0] line;
  logic [AW-1:0] base;
  logic [AW-1:0] fill_ptr;
  logic [AW-1:0] fill_last;
  logic [15:0]   fill_word;
  logic          res_read;

  logic [TW-1:0] col_ext;
  logic [TW-1:0] tab_col;
  logic [TW-1:0] col_t;
  logic [LW:0]   line_t;
  logic          scroll;
  logic [CW-1:0] col_new;
  logic [LW-1:0] line_new;

  logic [AW:0]   lin_idx;
  logic [AW:0]   cur_sum;
  logic [AW-1:0] cur_phys;
  logic [AW:0]   base_sum;
  logic [AW-1:0] base_next;
  logic [SW-1:0] ra;
  logic [SW-1:0] ra_sum;
  logic          ra_ok;
  logic [AW-1:0] ra_phys;

  logic          out_free;
  logic          mem_we;
  logic [AW-1:0] waddr;
  logic [15:0]   wdata;
  logic          rd_en;
  logic          load_out;
  logic          fill_done;

  logic [31:0]   pos_wide;
  logic [31:0]   col_wide;
  logic [31:0]   row_wide;

  // Cursor movement.
  always_comb begin
    tab_col = TW'(MAXM * TAB_STOP);
    col_ext = TW'(col);
    for (int m = MAXM; m >= 1; m--) begin
      if (TW'(m * TAB_STOP) > col_ext) begin
        tab_col = TW'(m * TAB_STOP);
      end
    end
  end

  always_comb begin
    col_t  = col_ext;
    line_t = (LW+1)'(line);
    scroll = 1'b0;
    case (head.op)
      OP_GLYPH: col_t = col_ext + 1'b1;
      OP_BS:    col_t = (col != '0) ? col_ext - 1'b1 : col_ext;
      OP_TAB:   col_t = tab_col;
      OP_CR:    col_t = '0;
      OP_LF: begin
        col_t  = '0;
        line_t = line_t + 1'b1;
      end
      default:  col_t = col_ext;
    endcase
    if (col_t >= TW'(COLUMNS)) begin
      col_t  = '0;
      line_t = line_t + 1'b1;
    end
    if (line_t >= (LW+1)'(ROWS)) begin
      scroll = 1'b1;
      line_t = (LW+1)'(ROWS - 1);
    end
    col_new  = col_t[CW-1:0];
    line_new = line_t[LW-1:0];
  end

  // Address arithmetic; the screen rotates by moving the base of the top row.
  always_comb begin
    lin_idx  = (AW+1)'(line) * (AW+1)'(COLUMNS) + (AW+1)'(col);
    cur_sum  = lin_idx + (AW+1)'(base);
    if (cur_sum >= (AW+1)'(CELLS)) begin
      cur_sum = cur_sum - (AW+1)'(CELLS);
    end
    cur_phys = cur_sum[AW-1:0];

    base_sum = (AW+1)'(base) + (AW+1)'(COLUMNS);
    if (base_sum >= (AW+1)'(CELLS)) begin
      base_sum = '0;
    end
    base_next = base_sum[AW-1:0];

    ra     = SW'(head.addr);
    ra_ok  = (ra < SW'(CELLS));
    ra_sum = ra + SW'(base);
    if (ra_sum >= SW'(CELLS)) begin
      ra_sum = ra_sum - SW'(CELLS);
    end
    ra_phys = ra_sum[AW-1:0];
  end

  assign out_free  = !out_valid || !out_stall;
  assign fill_done = (fill_ptr == fill_last);

  always_comb begin
    state_next = state;
    case (state)
      ST_INIT: begin
        if (fill_done) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (!q_empty) begin
          if (head.op == OP_CLEAR || scroll) begin
            state_next = ST_FILL;
          end else begin
            state_next = ST_DONE;
          end
        end
      end
      ST_FILL: begin
        if (fill_done) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_INIT;
    endcase
  end

  always_comb begin
    q_pop     = 1'b0;
    mem_we    = 1'b0;
    waddr     = fill_ptr;
    wdata     = fill_word;
    rd_en     = 1'b0;
    load_out  = 1'b0;
    init_busy = 1'b0;
    case (state)
      ST_INIT: begin
        init_busy = 1'b1;
        mem_we    = 1'b1;
      end
      ST_IDLE: begin
        q_pop  = !q_empty;
        mem_we = !q_empty && (head.op == OP_GLYPH);
        waddr  = cur_phys;
        wdata  = {attr, head.ch};
        rd_en  = !q_empty && (head.op == OP_READ);
      end
      ST_FILL:  mem_we   = 1'b1;
      ST_DONE:  load_out = out_free;
      default:  init_busy = 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[waddr] <= wdata;
    end
    if (rd_en) begin
      rd_data <= mem[ra_phys];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_INIT;
      attr      <= RESET_ATTR;
      col       <= '0;
      line      <= '0;
      base      <= '0;
      fill_ptr  <= '0;
      fill_last <= AW'(CELLS - 1);
      fill_word <= RESET_BLANK;
      res_read  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (attr_we) begin
        attr <= attr_data;
      end
      if ((state == ST_INIT || state == ST_FILL) && !fill_done) begin
        fill_ptr <= fill_ptr + 1'b1;
      end
      if (q_pop) begin
        res_read <= (head.op == OP_READ) && ra_ok;
        if (head.op == OP_CLEAR) begin
          col       <= '0;
          line      <= '0;
          base      <= '0;
          fill_ptr  <= '0;
          fill_last <= AW'(CELLS - 1);
          fill_word <= {attr, CH_SPACE};
        end else begin
          col  <= col_new;
          line <= line_new;
          if (scroll) begin
            base      <= base_next;
            fill_ptr  <= base;
            fill_last <= base + AW'(COLUMNS - 1);
            fill_word <= {attr, CH_SPACE};
          end
        end
      end
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign pos_wide = 32'(lin_idx);
  assign col_wide = 32'(col);
  assign row_wide = 32'(line);

  always_ff @(posedge clk) begin
    if (load_out) begin
      read_cell  <= res_read ? rd_data : 16'h0000;
      cursor_pos <= pos_wide[10:0];
      cursor_col <= col_wide[6:0];
      cursor_row <= row_wide[4:0];
    end
  end

endmodule

`default_nettype wire

FILE: design/text_console_char_engine.sv
// Top level of the text console character engine.
// A put, read or ignored beat is queued, executed by the back end and then shown as
// a registered result beat. A put that scrolls also blanks the new bottom row; a clear
// blanks every cell, one memory write per cell. The queue takes beats meanwhile; the
// back end finishes one beat's execute and result-hand-off steps before the next.
// Reset is synchronous; afterward the input stalls while the screen is blanked.
`default_nettype none

module text_console_char_engine
  import tcce_pkg::*;
#(
  parameter int COLUMNS  = 80,
  parameter int ROWS     = 25,
  parameter int TAB_STOP = 8
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  cmd,
  input  wire logic [7:0]  char_code,
  input  wire logic [10:0] read_addr,
  input  wire logic        text_attribute_valid,
  output logic             text_attribute_ready,
  input  wire logic [7:0]  text_attribute,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [15:0]      read_cell,
  output logic [10:0]      cursor_pos,
  output logic [6:0]       cursor_col,
  output logic [4:0]       cursor_row
);

  q_entry_t push_entry;
  q_entry_t head;
  logic     push;
  logic     pop;
  logic     q_full;
  logic     q_empty;
  logic     init_busy;

  assign text_attribute_ready = 1'b1;

  tcce_front u_front (
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .cmd        (cmd),
    .char_code  (char_code),
    .read_addr  (read_addr),
    .q_full     (q_full),
    .init_busy  (init_busy),
    .push       (push),
    .push_entry (push_entry)
  );

  tcce_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .head       (head),
    .full       (q_full),
    .empty      (q_empty)
  );

  tcce_back #(
    .COLUMNS  (COLUMNS),
    .ROWS     (ROWS),
    .TAB_STOP (TAB_STOP)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .head       (head),
    .q_empty    (q_empty),
    .q_pop      (pop),
    .init_busy  (init_busy),
    .attr_we    (text_attribute_valid && text_attribute_ready),
    .attr_data  (text_attribute),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .read_cell  (read_cell),
    .cursor_pos (cursor_pos),
    .cursor_col (cursor_col),
    .cursor_row (cursor_row)
  );

endmodule

`default_nettype wire

FILE: design/tcce_checker.sv
// Port-level checker for the text console character engine and its bind.
`default_nettype none

module tcce_checker #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        in_stall,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic [15:0] read_cell,
  input wire logic [10:0] cursor_pos,
  input wire logic [6:0]  cursor_col,
  input wire logic [4:0]  cursor_row
);

  // The screen is blanked after reset, so no beat is taken and none is offered.
  a_reset_sweep: assert property (@(posedge clk)
    rst |=> (in_stall && !out_valid))
    else $error("input open or result shown right after reset");

  a_col_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (32'(cursor_col) < COLUMNS))
    else $error("cursor column beyond the last column");

  a_row_range: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (ROWS <= 32)) |-> (32'(cursor_row) < ROWS))
    else $error("cursor row beyond the last row");

  a_pos_match: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (ROWS <= 32)) |->
      (cursor_pos == 11'(32'(cursor_row) * COLUMNS + 32'(cursor_col))))
    else $error("linear cursor position disagrees with row and column");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(read_cell)))
    else $error("stalled result beat changed");

endmodule

bind text_console_char_engine tcce_checker #(
  .COLUMNS (COLUMNS),
  .ROWS    (ROWS)
) u_tcce_checker (
  .clk        (clk),
  .rst        (rst),
  .in_stall   (in_stall),
  .out_valid  (out_valid),
  .out_stall  (out_stall),
  .read_cell  (read_cell),
  .cursor_pos (cursor_pos),
  .cursor_col (cursor_col),
  .cursor_row (cursor_row)
);

`default_nettype wire
